[src/pocd_pkg.sv]
// ---------------------------------------------------------------------------
// pocd_pkg
// Shared types and constants for the playfield object collision detector:
// operation codes, pen codes, collision code bits and tank position entries.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pocd_pkg;

   // Number of tanks with position storage
   localparam int NumTanks = 8;
   // Compare width wide enough for any tank number up to 16
   localparam int IdxCmpW  = 5;

   // Operation codes of an input beat
   typedef enum logic [1:0] {
      OP_PIXEL    = 2'd0,
      OP_WR_HORIZ = 2'd1,
      OP_WR_VERT  = 2'd2,
      OP_WR_DIR   = 2'd3
   } op_type;

   // Layer pen codes
   localparam logic [4:0] PenWall  = 5'h11;
   localparam logic [4:0] PenMine  = 5'h13;
   localparam logic [3:0] PenEmpty = 4'h8;

   // Collision code bits
   localparam logic [7:0] CodeTank   = 8'h10;
   localparam logic [7:0] CodeBullet = 8'h18;
   localparam logic [7:0] CodeWall   = 8'h20;
   localparam logic [7:0] CodeBottom = 8'h40;
   localparam logic [7:0] CodeRight  = 8'h80;

   // Screen position derivation: x = 498 - h - 256*d, y = 2*v - 62
   localparam int ScreenXBase = 498;
   localparam int ScreenYBase = 62;
   localparam int SideMargin  = 8;
   localparam int DirWeight   = 256;

   // One tank's stored position
   typedef struct packed {
      logic [7:0] horiz;
      logic [7:0] vert;
      logic       dir_high;
   } pos_entry_type;

   // Position write command toward the table
   typedef struct packed {
      logic       en;
      op_type     op;
      logic [2:0] idx;
      logic [7:0] data;
   } pos_write_type;

endpackage

`default_nettype wire

[src/pocd_pos_table.sv]
// ---------------------------------------------------------------------------
// pocd_pos_table
// Per-tank position registers: horizontal byte, vertical byte and the high
// bit of the direction byte, with one write port and one lookup port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pocd_pos_table (
   input  wire                    clock,
   input  wire                    reset,
   input  wire pocd_pkg::pos_write_type wr,
   input  wire  [2:0]             rd_idx,
   output pocd_pkg::pos_entry_type rd_entry
);
   import pocd_pkg::*;

   pos_entry_type tank_ff [NumTanks];

   // Load the addressed entry; writes beyond the tank count fall away
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumTanks; i++) begin
            tank_ff[i] <= '0;
         end
      end else if (wr.en) begin
         for (int i = 0; i < NumTanks; i++) begin
            if ({2'b00, wr.idx} == IdxCmpW'(i)) begin
               case (wr.op)
                  OP_WR_HORIZ: tank_ff[i].horiz    <= wr.data;
                  OP_WR_VERT:  tank_ff[i].vert     <= wr.data;
                  OP_WR_DIR:   tank_ff[i].dir_high <= wr.data[7];
                  default: ;
               endcase
            end
         end
      end
   end

   // Select the tank under the pen; unknown tanks read as zero
   always_comb begin
      rd_entry = '0;
      for (int i = 0; i < NumTanks; i++) begin
         if ({2'b00, rd_idx} == IdxCmpW'(i)) begin
            rd_entry = tank_ff[i];
         end
      end
   end

endmodule

`default_nettype wire

[src/pocd_hit_check.sv]
// ---------------------------------------------------------------------------
// pocd_hit_check
// Pixel collision decision: pen tests, interlace filter, run flag and
// assembly of the collision code with the tank side bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pocd_hit_check (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     fire,
   input  wire  [8:0]              pixel_x,
   input  wire  [8:0]              pixel_y,
   input  wire                     line_start,
   input  wire                     frame_parity,
   input  wire  [4:0]              playfield_pen,
   input  wire  [3:0]              tank_pen,
   input  wire  [3:0]              bullet_pen,
   input  wire pocd_pkg::pos_entry_type tank_pos,
   output logic                    hit,
   output logic [7:0]              code
);
   import pocd_pkg::*;

   logic run_flag_ff;
   logic run_flag_in;
   logic run_cur;
   logic is_wall;
   logic is_mine;
   logic tank_none;
   logic bullet_none;
   logic no_coll;
   logic [9:0]  bottom_lhs;
   logic [9:0]  bottom_rhs;
   logic [10:0] right_lhs;
   logic        side_bottom;
   logic        side_right;

   // Decode pens and the run state seen by this pixel
   always_comb begin
      run_cur     = line_start ? 1'b0 : run_flag_ff;
      is_wall     = (playfield_pen == PenWall);
      is_mine     = (playfield_pen == PenMine);
      tank_none   = (tank_pen == PenEmpty);
      bullet_none = (bullet_pen == PenEmpty);
      no_coll     = !(is_wall || is_mine) || (tank_none && bullet_none)
                    || (!bullet_none && is_mine);
   end

   // Compare pixel with the tank's derived corner, moved to unsigned sums
   always_comb begin
      bottom_lhs  = 10'(pixel_y) + 10'(ScreenYBase - SideMargin);
      bottom_rhs  = {1'b0, tank_pos.vert, 1'b0};
      side_bottom = (bottom_lhs >= bottom_rhs);
      right_lhs   = 11'(pixel_x) + 11'(tank_pos.horiz)
                    + (tank_pos.dir_high ? 11'(DirWeight) : 11'd0);
      side_right  = (right_lhs >= 11'(ScreenXBase + SideMargin));
   end

   // Decide result and next run flag
   always_comb begin
      hit         = 1'b0;
      run_flag_in = run_cur;
      if (pixel_y[0] != frame_parity) begin
         run_flag_in = run_cur;
      end else if (no_coll) begin
         run_flag_in = 1'b0;
      end else if (run_cur) begin
         run_flag_in = 1'b1;
      end else begin
         hit         = 1'b1;
         run_flag_in = 1'b1;
      end
   end

   // Build the collision code; bullet wins over tank
   always_comb begin
      if (!bullet_none) begin
         code = CodeBullet | CodeWall | CodeRight | {5'd0, bullet_pen[3:1]};
      end else begin
         code = CodeTank | {5'd0, tank_pen[3:1]};
         if (is_wall) begin
            code = code | CodeWall;
         end
         if (side_bottom) begin
            code = code | CodeBottom;
         end
         if (side_right) begin
            code = code | CodeRight;
         end
      end
   end

   // Advance the run flag on each processed pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         run_flag_ff <= 1'b0;
      end else if (fire) begin
         run_flag_ff <= run_flag_in;
      end
   end

endmodule

`default_nettype wire

[src/playfield_object_collision_detector.sv]
// Results: only a pixel beat that hits yields a result beat, held in the result register.
// Throughput: one beat per cycle; the input register and the result register
// form a two-stage pipeline, and the input side stalls only while a held
// result is stalled and the input register is full.
// Reset: clears both valid flags, the run flag and all tank positions.
// ---------------------------------------------------------------------------
// playfield_object_collision_detector
// Top level: input register, position table, collision check and result
// register with valid/stall handshakes on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module playfield_object_collision_detector (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [1:0] req_operation,
   input  wire  [2:0] req_object_index,
   input  wire  [7:0] req_write_data,
   input  wire  [8:0] req_pixel_x,
   input  wire  [8:0] req_pixel_y,
   input  wire        req_line_start,
   input  wire        req_frame_parity,
   input  wire  [4:0] req_playfield_pen,
   input  wire  [3:0] req_tank_pen,
   input  wire  [3:0] req_bullet_pen,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [7:0] rsp_collision_code,
   output logic [8:0] rsp_hit_x,
   output logic [8:0] rsp_hit_y
);
   import pocd_pkg::*;

   // Input register
   logic       in_vld_ff;
   op_type     op_ff;
   logic [2:0] idx_ff;
   logic [7:0] data_ff;
   logic [8:0] px_ff;
   logic [8:0] py_ff;
   logic       lstart_ff;
   logic       parity_ff;
   logic [4:0] pf_ff;
   logic [3:0] tp_ff;
   logic [3:0] bp_ff;

   // Result register
   logic       out_vld_ff;
   logic [7:0] code_ff;
   logic [8:0] hx_ff;
   logic [8:0] hy_ff;

   logic          out_free;
   logic          take_in;
   logic          process;
   logic          pixel_fire;
   logic          hit;
   logic [7:0]    code;
   pos_write_type pos_wr;
   pos_entry_type tank_pos;

   // Handshake control
   assign out_free   = !out_vld_ff || !rsp_stall;
   assign req_stall  = in_vld_ff && !out_free;
   assign take_in    = req_valid && !req_stall;
   assign process    = in_vld_ff && out_free;
   assign pixel_fire = process && (op_ff == OP_PIXEL);

   always_comb begin
      pos_wr.en   = process && (op_ff != OP_PIXEL);
      pos_wr.op   = op_ff;
      pos_wr.idx  = idx_ff;
      pos_wr.data = data_ff;
   end

   // Hold the input beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (take_in) begin
         in_vld_ff <= 1'b1;
      end else if (process) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         op_ff     <= op_type'(req_operation);
         idx_ff    <= req_object_index;
         data_ff   <= req_write_data;
         px_ff     <= req_pixel_x;
         py_ff     <= req_pixel_y;
         lstart_ff <= req_line_start;
         parity_ff <= req_frame_parity;
         pf_ff     <= req_playfield_pen;
         tp_ff     <= req_tank_pen;
         bp_ff     <= req_bullet_pen;
      end
   end

   pocd_pos_table u_pos_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (pos_wr),
      .rd_idx   (tp_ff[3:1]),
      .rd_entry (tank_pos)
   );

   pocd_hit_check u_hit_check (
      .clock         (clock),
      .reset         (reset),
      .fire          (pixel_fire),
      .pixel_x       (px_ff),
      .pixel_y       (py_ff),
      .line_start    (lstart_ff),
      .frame_parity  (parity_ff),
      .playfield_pen (pf_ff),
      .tank_pen      (tp_ff),
      .bullet_pen    (bp_ff),
      .tank_pos      (tank_pos),
      .hit           (hit),
      .code          (code)
   );

   // Advance the result register whenever it is free
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_free) begin
         out_vld_ff <= pixel_fire && hit;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_fire && hit) begin
         code_ff <= code;
         hx_ff   <= px_ff;
         hy_ff   <= py_ff;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_collision_code = code_ff;
   assign rsp_hit_x          = hx_ff;
   assign rsp_hit_y          = hy_ff;

`ifndef SYNTHESIS
   // A position write never yields a result beat
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      process && (op_ff != OP_PIXEL) |=> !rsp_valid)
      else $error("position write produced a result");

   // A bullet code carries wall and right bits and never the bottom bit
   a_bullet_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_collision_code[3]
         |-> rsp_collision_code[5] && rsp_collision_code[7]
             && !rsp_collision_code[6])
      else $error("malformed bullet collision code");

   // Every result carries an object kind bit
   a_kind_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_collision_code[4])
      else $error("collision code without object kind");

   // The input side stalls only with a full input register
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && out_vld_ff && rsp_stall)
      else $error("input stalled without backpressure");
`endif

endmodule

`default_nettype wire

[tb/sv/collision_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// collision_checker
// Watches the pixel and collision channels of the playfield object collision
// detector. Mirrors the tank position table and run flag, predicts the
// collision beat each accepted input beat should cause, and compares every
// accepted result beat against the oldest prediction.
// ---------------------------------------------------------------------------

module collision_checker (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   input  wire        req_stall,
   input  wire  [1:0] req_operation,
   input  wire  [2:0] req_object_index,
   input  wire  [7:0] req_write_data,
   input  wire  [8:0] req_pixel_x,
   input  wire  [8:0] req_pixel_y,
   input  wire        req_line_start,
   input  wire        req_frame_parity,
   input  wire  [4:0] req_playfield_pen,
   input  wire  [3:0] req_tank_pen,
   input  wire  [3:0] req_bullet_pen,
   input  wire        rsp_valid,
   input  wire        rsp_stall,
   input  wire  [7:0] rsp_collision_code,
   input  wire  [8:0] rsp_hit_x,
   input  wire  [8:0] rsp_hit_y,
   output int         mismatch_count,
   output int         pending_hits
);
   import pocd_pkg::*;

   typedef struct packed {
      logic [7:0] code;
      logic [8:0] x;
      logic [8:0] y;
   } hit_rec_type;

   hit_rec_type   expected_hits[$];
   pos_entry_type tank_pos [NumTanks];
   logic          run_active;

   // Count a mismatch; report only the first few
   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t ns: mismatch: %s", $time, what);
   endtask

   // Update the run flag for one pixel and return 1 with its code on a hit
   function automatic bit pixel_hit(input logic [8:0] px, input logic [8:0] py,
                                    input logic ls, input logic par,
                                    input logic [4:0] pf, input logic [3:0] tp,
                                    input logic [3:0] bp, output logic [7:0] code);
      int         tx;
      int         ty;
      int         n;
      logic [7:0] h;
      logic [7:0] v;
      logic       d;
      code = '0;
      if (ls)
         run_active = 1'b0;
      // other interlace line: nothing checked, run left alone
      if (py[0] != par)
         return 1'b0;
      if (pf != PenWall && pf != PenMine) begin
         run_active = 1'b0;
         return 1'b0;
      end
      if (tp == PenEmpty && bp == PenEmpty) begin
         run_active = 1'b0;
         return 1'b0;
      end
      // bullets pass over mines
      if (bp != PenEmpty && pf == PenMine) begin
         run_active = 1'b0;
         return 1'b0;
      end
      if (run_active)
         return 1'b0;
      if (bp != PenEmpty) begin
         code = {5'b0, bp[3:1]} | CodeBullet | CodeWall | CodeRight;
      end else begin
         n = int'(tp[3:1]);
         h = '0;
         v = '0;
         d = 1'b0;
         if (n < NumTanks) begin
            h = tank_pos[n].horiz;
            v = tank_pos[n].vert;
            d = tank_pos[n].dir_high;
         end
         tx = ScreenXBase - int'(h) - DirWeight * int'(d);
         ty = 2 * int'(v) - ScreenYBase;
         code = {5'b0, tp[3:1]} | CodeTank;
         if (pf == PenWall)
            code = code | CodeWall;
         if (int'(py) - ty >= SideMargin)
            code = code | CodeBottom;
         if (int'(px) - tx >= SideMargin)
            code = code | CodeRight;
      end
      run_active = 1'b1;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      hit_rec_type want;
      logic [7:0]  code;
      if (reset) begin
         foreach (tank_pos[i])
            tank_pos[i] = '0;
         run_active = 1'b0;
         mismatch_count = 0;
         expected_hits.delete();
      end else begin
         // check a result beat against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_hits.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat: code %02h x %0d y %0d",
                                       rsp_collision_code, rsp_hit_x, rsp_hit_y));
            end else begin
               want = expected_hits.pop_front();
               if (rsp_collision_code !== want.code || rsp_hit_x !== want.x ||
                   rsp_hit_y !== want.y)
                  flag_mismatch($sformatf(
                     "expected code %02h x %0d y %0d, got code %02h x %0d y %0d",
                     want.code, want.x, want.y,
                     rsp_collision_code, rsp_hit_x, rsp_hit_y));
            end
         end
         // predict from an accepted input beat
         if (req_valid && !req_stall) begin
            case (op_type'(req_operation))
               OP_PIXEL: begin
                  if (pixel_hit(req_pixel_x, req_pixel_y, req_line_start,
                                req_frame_parity, req_playfield_pen, req_tank_pen,
                                req_bullet_pen, code))
                     expected_hits.push_back('{code: code, x: req_pixel_x,
                                               y: req_pixel_y});
               end
               OP_WR_HORIZ: begin
                  if (req_object_index < NumTanks)
                     tank_pos[req_object_index].horiz = req_write_data;
               end
               OP_WR_VERT: begin
                  if (req_object_index < NumTanks)
                     tank_pos[req_object_index].vert = req_write_data;
               end
               default: begin
                  if (req_object_index < NumTanks)
                     tank_pos[req_object_index].dir_high = req_write_data[7];
               end
            endcase
         end
      end
      pending_hits <= expected_hits.size();
   end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives the collision detector with position writes and raster lines of
// pixel beats, with random idling on both sides and one long result hold-off.
// The checker beside the block predicts and compares; this top gives the
// verdict.
// ---------------------------------------------------------------------------

module testbench;
   import pocd_pkg::*;

   localparam int StuckLimit  = 2000;
   localparam int TotalItems  = 1450;
   localparam int HoldAtBeat  = 400;
   localparam int HoldCycles  = 250;
   localparam int QuietFrom   = 700;
   localparam int QuietTo     = 1000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_operation = OP_PIXEL;
   logic [2:0] req_object_index = '0;
   logic [7:0] req_write_data = '0;
   logic [8:0] req_pixel_x = '0;
   logic [8:0] req_pixel_y = '0;
   logic       req_line_start = 1'b0;
   logic       req_frame_parity = 1'b0;
   logic [4:0] req_playfield_pen = '0;
   logic [3:0] req_tank_pen = PenEmpty;
   logic [3:0] req_bullet_pen = PenEmpty;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_collision_code;
   logic [8:0] rsp_hit_x;
   logic [8:0] rsp_hit_y;

   int         mismatch_count;
   int         pending_hits;
   int         items_sent = 0;
   int         req_beats = 0;
   int         stuck_cycles = 0;
   int         hold_left = 0;
   bit         hold_done = 1'b0;
   logic       req_fire;
   logic       rsp_fire;
   logic       quiet;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;
   assign quiet    = (req_beats >= QuietFrom) && (req_beats < QuietTo);

   always #4 clock = ~clock;

   playfield_object_collision_detector dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_object_index   (req_object_index),
      .req_write_data     (req_write_data),
      .req_pixel_x        (req_pixel_x),
      .req_pixel_y        (req_pixel_y),
      .req_line_start     (req_line_start),
      .req_frame_parity   (req_frame_parity),
      .req_playfield_pen  (req_playfield_pen),
      .req_tank_pen       (req_tank_pen),
      .req_bullet_pen     (req_bullet_pen),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_collision_code (rsp_collision_code),
      .rsp_hit_x          (rsp_hit_x),
      .rsp_hit_y          (rsp_hit_y)
   );

   collision_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_object_index   (req_object_index),
      .req_write_data     (req_write_data),
      .req_pixel_x        (req_pixel_x),
      .req_pixel_y        (req_pixel_y),
      .req_line_start     (req_line_start),
      .req_frame_parity   (req_frame_parity),
      .req_playfield_pen  (req_playfield_pen),
      .req_tank_pen       (req_tank_pen),
      .req_bullet_pen     (req_bullet_pen),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_collision_code (rsp_collision_code),
      .rsp_hit_x          (rsp_hit_x),
      .rsp_hit_y          (rsp_hit_y),
      .mismatch_count     (mismatch_count),
      .pending_hits       (pending_hits)
   );

   // Count accepted input beats; they pace the hold-off and the quiet stretch
   always @(posedge clock) begin
      if (reset)
         req_beats <= 0;
      else if (req_fire)
         req_beats <= req_beats + 1;
   end

   // Stall results at random, hold off once for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && req_beats >= HoldAtBeat) begin
         hold_done <= 1'b1;
         hold_left <= HoldCycles;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 28);
      end
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= StuckLimit) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Offer one beat, with random idle cycles ahead of it, and wait for it to go
   task automatic send_beat(input op_type op, input logic [2:0] idx,
                            input logic [7:0] data, input logic [8:0] px,
                            input logic [8:0] py, input logic ls, input logic par,
                            input logic [4:0] pf, input logic [3:0] tp,
                            input logic [3:0] bp);
      while (!quiet && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_object_index  <= idx;
      req_write_data    <= data;
      req_pixel_x       <= px;
      req_pixel_y       <= py;
      req_line_start    <= ls;
      req_frame_parity  <= par;
      req_playfield_pen <= pf;
      req_tank_pen      <= tp;
      req_bullet_pen    <= bp;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
   endtask

   // Position write; the pixel fields carry noise
   task automatic write_pos(input op_type op, input logic [2:0] idx,
                            input logic [7:0] data);
      send_beat(op, idx, data, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                4'($urandom_range(0, 15)));
   endtask

   // Pixel beat; the write fields carry noise
   task automatic send_pixel(input logic [8:0] px, input logic [8:0] py,
                             input logic ls, input logic par, input logic [4:0] pf,
                             input logic [3:0] tp, input logic [3:0] bp);
      send_beat(OP_PIXEL, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                px, py, ls, par, pf, tp, bp);
   endtask

   initial begin
      int unsigned pick;
      int unsigned r;
      int unsigned line_len;
      int unsigned seg_left;
      logic [8:0]  lx;
      logic [8:0]  ly;
      logic        lpar;
      logic        ls;
      logic [4:0]  pf;
      logic [3:0]  seg_tank;
      logic [3:0]  seg_bullet;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // tank 0 at x 498, y 18; tank 7 at x -13, y 448
      write_pos(OP_WR_HORIZ, 3'd0, 8'h00);
      write_pos(OP_WR_VERT,  3'd0, 8'd40);
      write_pos(OP_WR_DIR,   3'd0, 8'h7f);
      write_pos(OP_WR_HORIZ, 3'd7, 8'hff);
      write_pos(OP_WR_VERT,  3'd7, 8'hff);
      write_pos(OP_WR_DIR,   3'd7, 8'h80);
      // tank on wall just short of both side thresholds, then a repeat in the run
      send_pixel(9'd505, 9'd25, 1'b1, 1'b1, PenWall, 4'd1, PenEmpty);
      send_pixel(9'd506, 9'd25, 1'b0, 1'b1, PenWall, 4'd1, PenEmpty);
      // open floor ends the run, next wall pixel crosses the right threshold
      send_pixel(9'd507, 9'd25, 1'b0, 1'b1, 5'd0, 4'd1, PenEmpty);
      send_pixel(9'd508, 9'd25, 1'b0, 1'b1, PenWall, 4'd1, PenEmpty);
      // tank on mine at the bottom threshold
      send_pixel(9'd0, 9'd26, 1'b1, 1'b0, PenMine, 4'd1, PenEmpty);
      // both object layers empty, then bullet over mine
      send_pixel(9'd1, 9'd26, 1'b0, 1'b0, PenWall, PenEmpty, PenEmpty);
      send_pixel(9'd2, 9'd26, 1'b0, 1'b0, PenMine, PenEmpty, 4'd3);
      // bullet and tank together on wall
      send_pixel(9'd3, 9'd26, 1'b0, 1'b0, PenWall, 4'd15, 4'd15);
      // wrong interlace line keeps the run; even pen repeats in the run
      send_pixel(9'd4, 9'd26, 1'b0, 1'b1, PenWall, 4'd15, PenEmpty);
      send_pixel(9'd5, 9'd26, 1'b0, 1'b0, PenWall, 4'd14, PenEmpty);
      // a write with line start set leaves the run alone
      send_beat(OP_WR_HORIZ, 3'd3, 8'h5a, 9'd0, 9'd0, 1'b1, 1'b0, 5'd0,
                PenEmpty, PenEmpty);
      send_pixel(9'd6, 9'd26, 1'b0, 1'b0, PenWall, 4'd14, PenEmpty);
      // far corner with tank 7, then the origin with an even pen on a mine
      send_pixel(9'd511, 9'd511, 1'b1, 1'b1, PenWall, 4'd15, PenEmpty);
      send_pixel(9'd0, 9'd0, 1'b1, 1'b0, PenMine, 4'd0, PenEmpty);
      send_pixel(9'd300, 9'd100, 1'b1, 1'b0, 5'h1f, 4'd3, 4'd5);
      write_pos(OP_WR_HORIZ, 3'd7, 8'h00);
      write_pos(OP_WR_DIR,   3'd7, 8'hff);

      // random raster lines, position bursts and noise
      while (items_sent < TotalItems) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            send_beat(op_type'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                      8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
                      9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                      4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         end else if (pick < 18) begin
            repeat ($urandom_range(1, 3))
               write_pos(op_type'($urandom_range(1, 3)), 3'($urandom_range(0, 7)),
                         8'($urandom_range(0, 255)));
         end else begin
            ly       = 9'($urandom_range(0, 511));
            lx       = 9'($urandom_range(0, 511));
            lpar     = ly[0] ^ ($urandom_range(0, 7) == 0);
            line_len = $urandom_range(4, 24);
            seg_left = 0;
            for (int i = 0; i < line_len; i++) begin
               // new stretch of object pens
               if (seg_left == 0) begin
                  seg_left = $urandom_range(1, 6);
                  r = $urandom_range(0, 9);
                  if (r < 6)
                     seg_tank = 4'(2 * $urandom_range(0, 7) + 1);
                  else if (r < 8)
                     seg_tank = PenEmpty;
                  else
                     seg_tank = 4'($urandom_range(0, 15));
                  seg_bullet = (r >= 7) ? 4'($urandom_range(0, 15)) : PenEmpty;
               end
               r = $urandom_range(0, 99);
               if (r < 45)
                  pf = PenWall;
               else if (r < 70)
                  pf = PenMine;
               else
                  pf = 5'($urandom_range(0, 31));
               ls = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
               send_pixel(lx, ly, ls, lpar, pf, seg_tank, seg_bullet);
               lx = lx + 9'd1;
               seg_left--;
            end
         end
      end
      req_valid <= 1'b0;

      // drain outstanding collisions, then let the pipeline settle
      @(posedge clock);
      while (pending_hits != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
